// ----- rtl/core/rotating_frame_iir_sequence_filter_top_macros.svh -----
// Assertion macros shared by the checker.
`ifndef ROTATING_FRAME_IIR_SEQUENCE_FILTER_TOP_MACROS_SVH
`define ROTATING_FRAME_IIR_SEQUENCE_FILTER_TOP_MACROS_SVH

// Implication checked in the following cycle, idle while reset is high.
`define RFSF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rfsf check failed");

// Implication checked in the following cycle, also across reset.
`define RFSF_ASSERT_ALWAYS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("rfsf check failed");

`endif

// ----- rtl/core/rfsf_pkg.sv -----
`default_nettype none
package rfsf_pkg;

  localparam int FILTER_ORDER    = 4;
  localparam int SINE_TABLE_BITS = 10;
  localparam int COEFF_FRAC_BITS = 20;
  localparam int STATE_FRAC      = 24;
  localparam int SAMPLE_FRAC     = 15;
  localparam int QBITS           = SINE_TABLE_BITS - 2;
  localparam int QSIZE           = 1 << QBITS;
  localparam int ACC_W           = 66;
  localparam int STATE_W         = 40;
  localparam int ROT_W           = 18;
  localparam int CFG_DATA_W      = 48;
  localparam int CFG_ADDR_W      = 3;
  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SEQ_SEL    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NUMER_01   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NUMER_23   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_NUMER_4    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DENOM_12   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DENOM_34   = 3'd6;

  typedef struct packed {
    logic signed [15:0] alpha_in;
    logic signed [15:0] beta_in;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] alpha_out;
    logic signed [15:0] beta_out;
  } out_item_t;

  // Rotated sample pair plus the rotation needed to undo it
  typedef struct packed {
    logic signed [ROT_W-1:0] ur;
    logic signed [ROT_W-1:0] ui;
    logic signed [15:0]      cosv;
    logic signed [15:0]      sinb;
  } work_t;

  // Filter coefficients; denom[0] is unused and held at zero
  typedef struct packed {
    logic [FILTER_ORDER:0][23:0] numer;
    logic [FILTER_ORDER:0][23:0] denom;
  } coeff_t;

  typedef enum logic [1:0] {F_IDLE, F_LOOK, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_MUL, B_ACC, B_RMUL, B_RACC} back_state_t;

  typedef logic [15:0] qtab_t [0:QSIZE];

  // Quarter-wave sine, Q30 Taylor series evaluated at elaboration
  function automatic qtab_t build_qtab();
    qtab_t t;
    longint unsigned x, x2, term;
    longint sum, r;
    for (int j = 0; j <= QSIZE; j++) begin
      x = (PIHALF_Q30 * longint'(j)) >> QBITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1: term = term / 6;
          2: term = term / 20;
          3: term = term / 42;
          4: term = term / 72;
          5: term = term / 110;
          default: term = term / 156;
        endcase
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + 16384) >>> 15;
      if (r > 32767) r = 32767;
      t[j] = r[15:0];
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Signed sine of a table phase by quadrant symmetry
  function automatic logic signed [15:0] table_sine(input logic [SINE_TABLE_BITS-1:0] p);
    logic [1:0]     quad;
    logic [QBITS:0] j;
    logic [15:0]    s;
    quad = p[SINE_TABLE_BITS-1 -: 2];
    j = {1'b0, p[QBITS-1:0]};
    s = quad[0] ? QTAB[(QBITS+1)'(QSIZE) - j] : QTAB[j];
    return quad[1] ? -$signed(s) : $signed(s);
  endfunction

  // Round half up by COEFF_FRAC_BITS bits, saturate to STATE_W
  function automatic logic signed [STATE_W-1:0] rnd_sat_state(
      input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] hi, lo;
    hi = (ACC_W'(1) <<< (STATE_W-1)) - 1;
    lo = -hi - 1;
    t = (acc + (ACC_W'(1) <<< (COEFF_FRAC_BITS-1))) >>> COEFF_FRAC_BITS;
    if (t > hi) t = hi;
    else if (t < lo) t = lo;
    return t[STATE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rotating_frame_iir_sequence_filter_top.sv -----
// Rotating-frame IIR filter for alpha/beta pairs. Push a sample pair while
// full is low; the pair is rotated by the running phase, each axis is run
// through a fourth-order IIR, and the result is rotated back and appears at
// the result side while empty is low. The front steps through capture,
// sine/cosine lookup and rotation into a two-entry queue; the back pops the
// queue, walks five taps for each of the two axes through its shared tap
// multiplier, a multiply step and an accumulate step per tap, and then does
// the back rotation. The front takes no new pair until it has pushed the last
// one into the queue, and once the queue backs up the back sets the pace.
// Write configuration only while idle.
`default_nettype none
module rotating_frame_iir_sequence_filter_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire rfsf_pkg::in_item_t                in_data,
  output logic                                   empty,
  input  wire logic                              pop,
  output rfsf_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rfsf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [rfsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [31:0] phase_step;
  logic        sequence_sel;
  logic [47:0] numer_01, numer_23, denom_12, denom_34;
  logic [23:0] numer_4;
  rfsf_pkg::coeff_t coeff;
  rfsf_pkg::work_t  q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      sequence_sel <= 1'b0;
      numer_01 <= '0;
      numer_23 <= '0;
      numer_4 <= '0;
      denom_12 <= '0;
      denom_34 <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        rfsf_pkg::REG_PHASE_STEP: phase_step <= cfg_data[31:0];
        rfsf_pkg::REG_SEQ_SEL:    sequence_sel <= cfg_data[0];
        rfsf_pkg::REG_NUMER_01:   numer_01 <= cfg_data;
        rfsf_pkg::REG_NUMER_23:   numer_23 <= cfg_data;
        rfsf_pkg::REG_NUMER_4:    numer_4 <= cfg_data[23:0];
        rfsf_pkg::REG_DENOM_12:   denom_12 <= cfg_data;
        rfsf_pkg::REG_DENOM_34:   denom_34 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coeff.numer = {numer_4, numer_23, numer_01};
  assign coeff.denom = {denom_34, denom_12, 24'd0};

  rfsf_front u_front (
    .clk, .rst, .push, .full, .in_data, .phase_step, .sequence_sel,
    .q_push, .q_full, .q_data(q_wdata)
  );

  rfsf_fifo u_fifo (
    .clk, .rst, .wr(q_push), .wdata(q_wdata), .full(q_full),
    .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  rfsf_back u_back (
    .clk, .rst, .coeff, .q_empty, .q_data(q_rdata), .q_pop,
    .empty, .pop, .out_data
  );

endmodule
`default_nettype wire

// ----- rtl/core/rfsf_front.sv -----
`default_nettype none
module rfsf_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire rfsf_pkg::in_item_t in_data,
  input  wire logic [31:0]      phase_step,
  input  wire logic             sequence_sel,
  output logic                  q_push,
  input  wire logic             q_full,
  output rfsf_pkg::work_t       q_data
);

  rfsf_pkg::front_state_t state, state_next;
  logic [31:0] phase_accum;
  logic [rfsf_pkg::SINE_TABLE_BITS-1:0] p;
  rfsf_pkg::in_item_t smp;
  logic signed [15:0] cosv, sinb;
  logic signed [32:0] ur_acc, ui_acc;
  logic accept;

  assign accept = push && !full;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rfsf_pkg::F_IDLE: if (accept) state_next = rfsf_pkg::F_LOOK;
      rfsf_pkg::F_LOOK: state_next = rfsf_pkg::F_PUSH;
      rfsf_pkg::F_PUSH: if (!q_full) state_next = rfsf_pkg::F_IDLE;
      default:          state_next = rfsf_pkg::F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    full = 1'b1;
    q_push = 1'b0;
    case (state)
      rfsf_pkg::F_IDLE: full = 1'b0;
      rfsf_pkg::F_PUSH: q_push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfsf_pkg::F_IDLE;
      phase_accum <= '0;
    end else begin
      state <= state_next;
      if (accept) phase_accum <= phase_accum + phase_step;
    end
  end

  // Capture sample and phase, then look up sine and cosine
  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= in_data;
      p <= phase_accum[31 -: rfsf_pkg::SINE_TABLE_BITS];
    end
    if (state == rfsf_pkg::F_LOOK) begin
      cosv <= rfsf_pkg::table_sine(p + rfsf_pkg::SINE_TABLE_BITS'(rfsf_pkg::QSIZE));
      sinb <= sequence_sel ? -rfsf_pkg::table_sine(p) : rfsf_pkg::table_sine(p);
    end
  end

  // Forward rotation, rounded to Q.15
  always_comb begin
    ur_acc = 33'(smp.alpha_in * cosv) + 33'(smp.beta_in * sinb) + 33'sd16384;
    ui_acc = 33'(smp.beta_in * cosv) - 33'(smp.alpha_in * sinb) + 33'sd16384;
    q_data.ur = ur_acc[32:15];
    q_data.ui = ui_acc[32:15];
    q_data.cosv = cosv;
    q_data.sinb = sinb;
  end

endmodule
`default_nettype wire

// ----- rtl/core/rfsf_fifo.sv -----
`default_nettype none
module rfsf_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr,
  input  wire rfsf_pkg::work_t wdata,
  output logic                 full,
  input  wire logic            rd,
  output rfsf_pkg::work_t      rdata,
  output logic                 empty
);

  rfsf_pkg::work_t mem [0:1];
  logic wp, rp;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

endmodule
`default_nettype wire

// ----- rtl/core/rfsf_back.sv -----
`default_nettype none
module rfsf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rfsf_pkg::coeff_t coeff,
  input  wire logic             q_empty,
  input  wire rfsf_pkg::work_t  q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output rfsf_pkg::out_item_t   out_data
);

  localparam int SW = rfsf_pkg::STATE_W;
  localparam int AW = rfsf_pkg::ACC_W;

  rfsf_pkg::back_state_t state, state_next;
  rfsf_pkg::work_t w;
  logic [2:0] k;
  logic path;
  logic signed [SW-1:0] z_r [0:3];
  logic signed [SW-1:0] z_i [0:3];
  logic signed [SW-1:0] y_r, y_i;
  logic signed [41:0] prod_b;
  logic signed [63:0] prod_a;
  logic signed [55:0] m1, m2, m3, m4;
  logic out_valid;
  logic slot_free, last_k, do_load;
  logic signed [rfsf_pkg::ROT_W-1:0] x_cur;
  logic signed [SW-1:0] y_cur, z_cur, res;
  logic signed [AW-1:0] acc;

  assign empty = !out_valid;
  assign slot_free = !out_valid || pop;
  assign last_k = (k == 3'(rfsf_pkg::FILTER_ORDER));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rfsf_pkg::B_IDLE: if (!q_empty) state_next = rfsf_pkg::B_MUL;
      rfsf_pkg::B_MUL:  state_next = rfsf_pkg::B_ACC;
      rfsf_pkg::B_ACC:  state_next = (last_k && path) ? rfsf_pkg::B_RMUL : rfsf_pkg::B_MUL;
      rfsf_pkg::B_RMUL: state_next = rfsf_pkg::B_RACC;
      rfsf_pkg::B_RACC: if (slot_free) state_next = rfsf_pkg::B_IDLE;
      default:          state_next = rfsf_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop = 1'b0;
    do_load = 1'b0;
    case (state)
      rfsf_pkg::B_IDLE: q_pop = !q_empty;
      rfsf_pkg::B_RACC: do_load = slot_free;
      default: ;
    endcase
  end

  // Operand selection and rounded tap sum for the current tap
  always_comb begin
    x_cur = path ? w.ui : w.ur;
    y_cur = path ? y_i : y_r;
    if (k < 3'(rfsf_pkg::FILTER_ORDER))
      z_cur = path ? z_i[k[1:0]] : z_r[k[1:0]];
    else
      z_cur = '0;
    acc = (AW'(prod_b) <<< (rfsf_pkg::STATE_FRAC - rfsf_pkg::SAMPLE_FRAC))
        + (AW'(z_cur) <<< rfsf_pkg::COEFF_FRAC_BITS) - AW'(prod_a);
    res = rfsf_pkg::rnd_sat_state(acc);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfsf_pkg::B_IDLE;
      out_valid <= 1'b0;
      k <= '0;
      path <= 1'b0;
    end else begin
      state <= state_next;
      if (do_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (q_pop) begin
        k <= '0;
        path <= 1'b0;
      end else if (state == rfsf_pkg::B_ACC) begin
        if (last_k) begin
          k <= '0;
          path <= 1'b1;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

  // Filter delay lines
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        z_r[i] <= '0;
        z_i[i] <= '0;
      end
    end else if (state == rfsf_pkg::B_ACC && k != 3'd0) begin
      if (path) z_i[2'(k - 3'd1)] <= res;
      else z_r[2'(k - 3'd1)] <= res;
    end
  end

  // Datapath: tap products, filter outputs, back rotation
  always_ff @(posedge clk) begin
    if (q_pop) w <= q_data;
    if (state == rfsf_pkg::B_MUL) begin
      prod_b <= $signed(coeff.numer[k]) * x_cur;
      prod_a <= (k == 3'd0) ? 64'sd0 : $signed(coeff.denom[k]) * y_cur;
    end
    if (state == rfsf_pkg::B_ACC && k == 3'd0) begin
      if (path) y_i <= res;
      else y_r <= res;
    end
    if (state == rfsf_pkg::B_RMUL) begin
      m1 <= y_r * w.cosv;
      m2 <= y_i * w.sinb;
      m3 <= y_r * w.sinb;
      m4 <= y_i * w.cosv;
    end
    if (do_load) begin
      out_data.alpha_out <= sat_out(57'(m1) - 57'(m2));
      out_data.beta_out <= sat_out(57'(m3) + 57'(m4));
    end
  end

  // Round half up from Q.39 to Q.15 and saturate
  function automatic logic signed [15:0] sat_out(input logic signed [56:0] v);
    logic signed [56:0] t;
    t = (v + (57'sd1 <<< (rfsf_pkg::STATE_FRAC - 1))) >>> rfsf_pkg::STATE_FRAC;
    if (t > 57'sd32767) t = 57'sd32767;
    else if (t < -57'sd32768) t = -57'sd32768;
    return t[15:0];
  endfunction

endmodule
`default_nettype wire

// ----- rtl/core/rfsf_checker.sv -----
`default_nettype none
`include "rotating_frame_iir_sequence_filter_top_macros.svh"
module rfsf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                push,
  input wire logic                full,
  input wire logic                empty,
  input wire logic                pop,
  input wire rfsf_pkg::out_item_t out_data
);

  // Nothing waits on the result side right after reset
  `RFSF_ASSERT_ALWAYS(a_reset_empty, rst, empty)
  // Front stays busy after each accepted transaction until it has queued the pair
  `RFSF_ASSERT_NEXT(a_push_busy, push && !full, full)
  // A waiting result stays put until taken
  `RFSF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_data))

endmodule

bind rotating_frame_iir_sequence_filter_top rfsf_checker u_rfsf_checker (
  .clk, .rst, .push, .full, .empty, .pop, .out_data
);
`default_nettype wire

// ----- test/rotating_frame_iir_sequence_filter_top_tb.sv -----
`default_nettype none
module rotating_frame_iir_sequence_filter_top_tb;
  import rfsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rotating_frame_iir_sequence_filter_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state and shadow registers
  logic [31:0] m_step;
  logic        m_neg;
  logic signed [23:0] m_b [0:4];
  logic signed [23:0] m_a [1:4];
  logic [31:0] m_phase;
  longint m_zr [0:3];
  longint m_zi [0:3];
  out_item_t filtered_q [$];

  int unsigned cycle_cnt = 0;
  int unsigned errors = 0;
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned phases = 0;
  bit hold_off = 1'b0;
  bit stall_en = 1'b1;

  function automatic longint round_sh(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  // quarter-wave sine via Q30 Taylor series
  function automatic longint qsine(int j);
    longint unsigned x, x2, term;
    longint sum, r;
    x = (PIHALF_Q30 * longint'(j)) >> QBITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 16384) >>> 15;
    return r > 32767 ? 32767 : r;
  endfunction

  function automatic longint sine_at(logic [SINE_TABLE_BITS-1:0] p);
    int j;
    longint s;
    j = int'(p[QBITS-1:0]);
    s = p[QBITS] ? qsine(QSIZE - j) : qsine(j);
    return p[QBITS+1] ? -s : s;
  endfunction

  // one filter section, updates delays in place
  function automatic longint iir_step(longint x, ref longint z [0:3]);
    longint y, acc;
    acc = longint'(m_b[0]) * x * 512 + z[0] * (longint'(1) <<< COEFF_FRAC_BITS);
    y = clip(round_sh(acc, COEFF_FRAC_BITS), STATE_W);
    for (int i = 1; i < 4; i++) begin
      acc = longint'(m_b[i]) * x * 512 + z[i] * (longint'(1) <<< COEFF_FRAC_BITS)
            - longint'(m_a[i]) * y;
      z[i-1] = clip(round_sh(acc, COEFF_FRAC_BITS), STATE_W);
    end
    acc = longint'(m_b[4]) * x * 512 - longint'(m_a[4]) * y;
    z[3] = clip(round_sh(acc, COEFF_FRAC_BITS), STATE_W);
    return y;
  endfunction

  function automatic out_item_t filter_pair(in_item_t it);
    logic [SINE_TABLE_BITS-1:0] p;
    longint s, c, a, b, ur, ui, xr, xi, sb;
    out_item_t r;
    p = m_phase[31 -: SINE_TABLE_BITS];
    s = sine_at(p);
    c = sine_at(p + SINE_TABLE_BITS'(QSIZE));
    a = longint'(it.alpha_in);
    b = longint'(it.beta_in);
    if (!m_neg) begin
      ur = round_sh(a * c + b * s, 15);
      ui = round_sh(b * c - a * s, 15);
      sb = s;
    end else begin
      ur = round_sh(a * c - b * s, 15);
      ui = round_sh(a * s + b * c, 15);
      sb = -s;
    end
    xr = iir_step(ur, m_zr);
    xi = iir_step(ui, m_zi);
    r.alpha_out = 16'(clip(round_sh(xr * c - xi * sb, STATE_FRAC), 16));
    r.beta_out = 16'(clip(round_sh(xr * sb + xi * c, STATE_FRAC), 16));
    m_phase = m_phase + m_step;
    return r;
  endfunction

  function automatic void model_write(logic [CFG_ADDR_W-1:0] idx, logic [47:0] v);
    case (idx)
      REG_PHASE_STEP: m_step = v[31:0];
      REG_SEQ_SEL:    m_neg = v[0];
      REG_NUMER_01:   begin m_b[0] = v[23:0]; m_b[1] = v[47:24]; end
      REG_NUMER_23:   begin m_b[2] = v[23:0]; m_b[3] = v[47:24]; end
      REG_NUMER_4:    m_b[4] = v[23:0];
      REG_DENOM_12:   begin m_a[1] = v[23:0]; m_a[2] = v[47:24]; end
      REG_DENOM_34:   begin m_a[3] = v[23:0]; m_a[4] = v[47:24]; end
      default: ;
    endcase
  endfunction

  // one write, then idle with cfg_we low before returning
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [47:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_write(idx, v);
    @(posedge clk);
  endtask

  // send one transaction, honoring full
  task automatic send_pair(in_item_t it);
    push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    filtered_q.push_back(filter_pair(it));
    sent++;
  endtask

  task automatic idle_gap();
    push <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t rand_pair();
    in_item_t it;
    it.alpha_in = 16'($urandom);
    it.beta_in = 16'($urandom);
    return it;
  endfunction

  // bursts of random pairs with random gaps; caller drops push afterwards
  task automatic send_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) send_pair(rand_pair());
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
  endtask

  // Q4.20 constant as 24 bits
  function automatic logic [23:0] q20(real v);
    return 24'($rtoi(v * 1048576.0));
  endfunction

  task automatic set_filter(logic [23:0] b0, logic [23:0] b1, logic [23:0] b2,
                            logic [23:0] b3, logic [23:0] b4, logic [23:0] a1,
                            logic [23:0] a2, logic [23:0] a3, logic [23:0] a4);
    cfg_write(REG_NUMER_01, {b1, b0});
    cfg_write(REG_NUMER_23, {b3, b2});
    cfg_write(REG_NUMER_4, {24'd0, b4});
    cfg_write(REG_DENOM_12, {a2, a1});
    cfg_write(REG_DENOM_34, {a4, a3});
  endtask

  // extremes of samples through a unity passthrough, both rotation senses
  task automatic test_directed();
    in_item_t it;
    logic [15:0] ext [0:5];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
    set_filter(q20(1.0), 0, 0, 0, 0, 0, 0, 0, 0);
    cfg_write(REG_PHASE_STEP, 32'h4000_0000);
    cfg_write(REG_SEQ_SEL, 48'd0);
    for (int i = 0; i < 12; i++) begin
      it.alpha_in = ext[i % 6];
      it.beta_in = ext[(i * 5 + 1) % 6];
      send_pair(it);
    end
    wait_idle();
    cfg_write(REG_SEQ_SEL, 48'd1);
    cfg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      it.alpha_in = ext[(i + 2) % 6];
      it.beta_in = ext[i % 6];
      send_pair(it);
    end
    wait_idle();
    phases++;
  endtask

  // low-pass style filter at a moderate shift
  task automatic test_lowpass();
    set_filter(q20(0.05), q20(0.1), q20(0.05), 0, 0, q20(-1.2), q20(0.4), 0, 0);
    cfg_write(REG_PHASE_STEP, 32'h0123_4567);
    cfg_write(REG_SEQ_SEL, 48'd0);
    send_random(400);
    wait_idle();
    phases++;
  endtask

  // full fourth order, negative sequence
  task automatic test_fourth_order();
    set_filter(q20(0.2), q20(-0.3), q20(0.4), q20(-0.1), q20(0.05),
               q20(-0.5), q20(0.3), q20(-0.1), q20(0.02));
    cfg_write(REG_PHASE_STEP, $urandom);
    cfg_write(REG_SEQ_SEL, 48'd1);
    send_random(400);
    wait_idle();
    phases++;
  endtask

  // extreme coefficients drive delays and outputs into saturation
  task automatic test_saturation();
    set_filter(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
               24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    cfg_write(REG_PHASE_STEP, 32'h8000_0001);
    send_random(300);
    wait_idle();
    phases++;
  endtask

  // random coefficients; receiver holds off so the input backs up
  task automatic test_backpressure();
    set_filter(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
               24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
               24'($urandom));
    cfg_write(REG_PHASE_STEP, $urandom);
    cfg_write(REG_SEQ_SEL, 48'($urandom_range(0, 1)));
    hold_off = 1'b1;
    send_random(500);
    wait_idle();
    phases++;
  endtask

  // receiver: pops on its own stall pattern; long hold-off on request
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 7);
      if (n < 2 && stall_en) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && pop && !empty) begin
      if (filtered_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = filtered_q.pop_front();
        checked++;
        if (out_data.alpha_out !== exp_r.alpha_out ||
            out_data.beta_out !== exp_r.beta_out) begin
          errors++;
          if (mismatches++ < 10)
            $display("result %0d: expected alpha %0d beta %0d, got alpha %0d beta %0d",
                     checked, exp_r.alpha_out, exp_r.beta_out,
                     out_data.alpha_out, out_data.beta_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("rotating_frame_iir_sequence_filter_top: mismatch");
      $finish;
    end
  end

  initial begin
    m_step = '0;
    m_neg = 1'b0;
    m_phase = '0;
    for (int i = 0; i < 5; i++) m_b[i] = '0;
    for (int i = 1; i < 5; i++) m_a[i] = '0;
    for (int i = 0; i < 4; i++) begin m_zr[i] = 0; m_zi[i] = 0; end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_lowpass();
    test_fourth_order();
    test_saturation();
    test_backpressure();
    if (filtered_q.size() != 0) errors++;
    $display("%0d phases, %0d pairs sent, %0d results checked, both sequences and",
             phases, sent, checked);
    $display("saturating coefficients covered, with a long receiver hold-off");
    if (errors == 0) begin
      $display("rotating_frame_iir_sequence_filter_top: match");
    end else begin
      $display("rotating_frame_iir_sequence_filter_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- rotating_frame_iir_sequence_filter_top.f -----
+incdir+rtl/core
rtl/core/rfsf_pkg.sv
rtl/core/rfsf_front.sv
rtl/core/rfsf_fifo.sv
rtl/core/rfsf_back.sv
rtl/core/rotating_frame_iir_sequence_filter_top.sv
rtl/core/rfsf_checker.sv
test/rotating_frame_iir_sequence_filter_top_tb.sv
